>>> sv/ktm_pkg.sv
package ktm_pkg;

    // field widths, fixed by the item format
    localparam int KIND_W  = 2;
    localparam int NODE_W  = 6;
    localparam int SYM_W   = 8;
    localparam int TOKEN_W = 4;

    // trie dimensions
    localparam int NODES   = 64;
    localparam int LETTERS = 26;
    localparam int TOKENS  = 16;

    localparam int FIRST_LETTER = 97;

    localparam int LINK_DEPTH = NODES * LETTERS;
    localparam int LINK_AW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam int TOK_AW     = (NODES > 1) ? $clog2(NODES) : 1;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((NODE_W + SYM_W + NODE_W + TOKEN_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((TOKEN_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_LINK  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_CHAR  = 2'd2
    } kind_t;

    function automatic logic is_letter(input logic [SYM_W-1:0] sym);
        is_letter = (int'(sym) >= FIRST_LETTER) && (int'(sym) < FIRST_LETTER + LETTERS);
    endfunction

    function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0] nd,
                                                     input logic [SYM_W-1:0]  sym);
        link_addr = LINK_AW'(int'(nd) * LETTERS + int'(sym) - FIRST_LETTER);
    endfunction

endpackage

>>> sv/keyword_trie_matcher.sv
// Keyword recogniser over a loadable prefix tree.
// Input channel s_*: one beat is a link write, a token write or one character
// of a word (kind on s_tuser, final character flagged by s_tlast). Output
// channel m_*: one beat per word, carrying its token number (0 = unknown or
// mismatch).
// Rate: load beats are taken every cycle while the token stage can take a
// result; a character beat holds s_tready low until it leaves the link stage,
// whose memory read gives the node addressed by the next character.
// Path: a final character passes the link read, the token read and the output
// register in turn before its token shows on m_tdata.
// Reset: aresetn clears the walk state, the token valid bits and the output;
// then a clearing pass zeroes the link memory, one entry a cycle, through all
// LINK_DEPTH (1664) entries, during which s_tready stays low.
// Stall: the output register holds a result while m_tready is low; one
// further result may wait in the token stage before s_tready drops.
module keyword_trie_matcher
    import ktm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [5:0] node, [13:6] symbol, [19:14] child, [23:20] token_value
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]   s_tuser,
    input  logic                s_tlast,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [3:0] token
    output logic [M_DATA_W-1:0] m_tdata
);

    // ---- input fields ----
    logic [NODE_W-1:0]  in_node;
    logic [SYM_W-1:0]   in_sym;
    logic [NODE_W-1:0]  in_child;
    logic [TOKEN_W-1:0] in_tval;
    logic               s_acc;

    assign in_node  = s_tdata[NODE_W-1:0];
    assign in_sym   = s_tdata[NODE_W+SYM_W-1:NODE_W];
    assign in_child = s_tdata[2*NODE_W+SYM_W-1:NODE_W+SYM_W];
    assign in_tval  = s_tdata[2*NODE_W+SYM_W+TOKEN_W-1:2*NODE_W+SYM_W];
    assign s_acc    = s_tvalid && s_tready;

    // ---- state ----
    logic               clr_active_reg, clr_active_next;
    logic [LINK_AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [NODE_W-1:0]  cur_node_reg, cur_node_next;
    logic               mismatch_reg, mismatch_next;

    // link read stage
    logic               b_vld_reg, b_vld_next;
    logic               b_read_reg;   // a link was actually looked up
    logic               b_last_reg;

    // token read stage
    logic               c_vld_reg, c_vld_next;
    logic               c_mis_reg;

    // output register
    logic               m_vld_reg, m_vld_next;
    logic [TOKEN_W-1:0] m_tok_reg;

    logic [NODE_W-1:0]  link_mem [LINK_DEPTH];
    logic [NODE_W-1:0]  link_rd_reg;
    logic [TOKEN_W-1:0] tok_mem [NODES];
    logic [TOKEN_W-1:0] tok_rd_reg;
    logic [NODES-1:0]   tok_vld_reg;
    logic               tok_vld_rd_reg;

    // ---- stage control ----
    logic               c_move, c_free, b_move;
    logic               eff_mis;
    logic [NODE_W-1:0]  eff_node;
    logic               tok_re;

    assign c_move = c_vld_reg && (!m_vld_reg || m_tready);
    assign c_free = !c_vld_reg || c_move;
    assign b_move = b_vld_reg && (!b_last_reg || c_free);

    // the walk after the character in the link stage
    assign eff_mis  = !b_read_reg || (link_rd_reg == '0);
    assign eff_node = eff_mis ? cur_node_reg : link_rd_reg;
    assign tok_re   = b_move && b_last_reg;

    // one character in flight at a time: its link feeds the next address
    assign s_tready = !clr_active_reg && !b_vld_reg && c_free;

    // ---- load decode ----
    logic link_we, tok_we, link_re;

    assign link_we = s_acc && (s_tuser == KIND_LINK) && (int'(in_node) < NODES) &&
                     (int'(in_child) < NODES) && is_letter(in_sym);
    assign tok_we  = s_acc && (s_tuser == KIND_TOKEN) && (int'(in_node) < NODES) &&
                     (int'(in_tval) < TOKENS);
    assign link_re = s_acc && (s_tuser == KIND_CHAR) && !mismatch_reg && is_letter(in_sym);

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (int'(clr_cnt_reg) == LINK_DEPTH - 1) begin
                clr_active_next = 1'b0;
            end
        end

        b_vld_next = b_vld_reg;
        if (b_move) begin
            b_vld_next = 1'b0;
        end
        if (s_acc && (s_tuser == KIND_CHAR)) begin
            b_vld_next = 1'b1;
        end

        cur_node_next = cur_node_reg;
        mismatch_next = mismatch_reg;
        if (b_move) begin
            if (b_last_reg) begin
                cur_node_next = '0;
                mismatch_next = 1'b0;
            end else begin
                cur_node_next = eff_node;
                mismatch_next = eff_mis;
            end
        end

        c_vld_next = c_vld_reg;
        if (c_move) begin
            c_vld_next = 1'b0;
        end
        if (tok_re) begin
            c_vld_next = 1'b1;
        end

        m_vld_next = m_vld_reg;
        if (m_tready) begin
            m_vld_next = 1'b0;
        end
        if (c_move) begin
            m_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            cur_node_reg   <= '0;
            mismatch_reg   <= 1'b0;
            b_vld_reg      <= 1'b0;
            c_vld_reg      <= 1'b0;
            m_vld_reg      <= 1'b0;
            tok_vld_reg    <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            cur_node_reg   <= cur_node_next;
            mismatch_reg   <= mismatch_next;
            b_vld_reg      <= b_vld_next;
            c_vld_reg      <= c_vld_next;
            m_vld_reg      <= m_vld_next;
            if (tok_we) begin
                tok_vld_reg[TOK_AW'(in_node)] <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            b_read_reg <= link_re;
            b_last_reg <= s_tlast;
        end
        if (tok_re) begin
            c_mis_reg      <= eff_mis;
            tok_vld_rd_reg <= tok_vld_reg[TOK_AW'(eff_node)];
        end
        if (c_move) begin
            m_tok_reg <= (c_mis_reg || !tok_vld_rd_reg) ? '0 : tok_rd_reg;
        end
    end

    // link memory: clearing pass has the write port until done
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            link_mem[clr_cnt_reg] <= '0;
        end else if (link_we) begin
            link_mem[link_addr(in_node, in_sym)] <= in_child;
        end
        if (link_re) begin
            link_rd_reg <= link_mem[link_addr(cur_node_reg, in_sym)];
        end
    end

    // token memory, entries qualified by tok_vld_reg
    always_ff @(posedge aclk) begin
        if (tok_we) begin
            tok_mem[TOK_AW'(in_node)] <= in_tval;
        end
        if (tok_re) begin
            tok_rd_reg <= tok_mem[TOK_AW'(eff_node)];
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = M_DATA_W'(m_tok_reg);

`ifndef SYNTH
    // a character in the link stage blocks the next beat
    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        b_vld_reg |-> !s_tready)
        else $error("beat accepted while a link lookup is pending");

    // nothing in flight during the clearing pass
    a_clr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> (!b_vld_reg && !c_vld_reg && !s_tready))
        else $error("pipeline active during link clearing");

    // a blocked token stage keeps its result (raw token data only matters when valid)
    a_c_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_vld_reg && !c_move) |=> (c_vld_reg && $stable(c_mis_reg) &&
            $stable(tok_vld_rd_reg) &&
            (c_mis_reg || !tok_vld_rd_reg || $stable(tok_rd_reg))))
        else $error("token stage lost a result under stall");

    // the walk is back at the root after a final character leaves the link stage
    a_word_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_move && b_last_reg) |=> (cur_node_reg == '0 && !mismatch_reg))
        else $error("walk not reset at end of word");
`endif

endmodule

>>> sim/keyword_trie_matcher_tb.sv
module keyword_trie_matcher_tb;
    import ktm_pkg::*;

    // kind code that the block must swallow without effect
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [5:0] node, [13:6] symbol, [19:14] child, [23:20] token_value
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // [1:0] kind
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [3:0] token
    logic [M_DATA_W-1:0] m_tdata;

    keyword_trie_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Shadow trie: link and token stores plus the walk position.
    // ---------------------------------------------------------------
    logic [NODE_W-1:0]  link_mem  [LINK_DEPTH];
    logic [TOKEN_W-1:0] token_mem [NODES];
    logic [NODE_W-1:0]  walk_node = '0;
    logic               walk_bad  = 1'b0;
    logic [TOKEN_W-1:0] token_due [$];   // tokens still owed by the block

    int errors     = 0;
    int beats_sent = 0;
    int burst_left = 0;
    int hold_left  = 0;   // receiver hold-off, counted down by the receiver
    int fresh_node = 8;   // next node handed out when growing the trie

    initial begin
        foreach (link_mem[i]) link_mem[i] = '0;
        foreach (token_mem[i]) token_mem[i] = '0;
    end

    // Apply one accepted beat to the shadow trie; a final character owes a token.
    function automatic void trie_apply(input logic [KIND_W-1:0]  k,
                                       input logic [NODE_W-1:0]  nd,
                                       input logic [SYM_W-1:0]   sym,
                                       input logic [NODE_W-1:0]  ch,
                                       input logic [TOKEN_W-1:0] tv,
                                       input logic               lst);
        bit                letter_ok;
        int                idx;
        logic [NODE_W-1:0] nxt;
        letter_ok = (int'(sym) >= FIRST_LETTER) && (int'(sym) < FIRST_LETTER + LETTERS);
        idx       = int'(sym) - FIRST_LETTER;
        case (k)
            KIND_LINK: begin
                if (letter_ok && int'(nd) < NODES && int'(ch) < NODES)
                    link_mem[int'(nd) * LETTERS + idx] = ch;
            end
            KIND_TOKEN: begin
                if (int'(nd) < NODES && int'(tv) < TOKENS)
                    token_mem[nd] = tv;
            end
            KIND_CHAR: begin
                // once the word has gone astray the walk stays put
                if (!walk_bad) begin
                    nxt = letter_ok ? link_mem[int'(walk_node) * LETTERS + idx] : '0;
                    if (nxt != '0)
                        walk_node = nxt;
                    else
                        walk_bad = 1'b1;
                end
                if (lst) begin
                    token_due.push_back(walk_bad ? {TOKEN_W{1'b0}} : token_mem[walk_node]);
                    walk_node = '0;
                    walk_bad  = 1'b0;
                end
            end
            default: ;   // unused kind: nothing happens
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Sender: one beat per call, driven at the falling edge, in bursts
    // of random length separated by random gaps (often none).
    // ---------------------------------------------------------------
    task automatic send_beat(input logic [KIND_W-1:0]  k,
                             input logic [NODE_W-1:0]  nd,
                             input logic [SYM_W-1:0]   sym,
                             input logic [NODE_W-1:0]  ch,
                             input logic [TOKEN_W-1:0] tv,
                             input logic               lst);
        int gap;
        s_tuser  = k;
        s_tdata  = {tv, ch, sym, nd};
        s_tlast  = lst;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        trie_apply(k, nd, sym, ch, tv, lst);
        beats_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            repeat (gap) @(negedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // don't-care fields carry random bits so every input bit toggles
    task automatic put_link(input int nd, input int sym, input int ch);
        send_beat(KIND_LINK, NODE_W'(nd), SYM_W'(sym), NODE_W'(ch),
                  TOKEN_W'($urandom), 1'($urandom));
    endtask

    task automatic put_token(input int nd, input int tv);
        send_beat(KIND_TOKEN, NODE_W'(nd), SYM_W'($urandom), NODE_W'($urandom),
                  TOKEN_W'(tv), 1'($urandom));
    endtask

    task automatic put_char(input int sym, input logic lst);
        send_beat(KIND_CHAR, NODE_W'($urandom), SYM_W'(sym), NODE_W'($urandom),
                  TOKEN_W'($urandom), lst);
    endtask

    // ---------------------------------------------------------------
    // Receiver: ready pattern follows a mode redrawn whenever mode_left runs out
    // (always ready, coin toss, mostly stalled, mostly ready). A hold-off
    // request overrides it while hold_left counts down.
    // ---------------------------------------------------------------
    int rx_mode   = 0;
    int mode_left = 0;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       m_tready = 1'b1;
                1:       m_tready = 1'($urandom_range(0, 1));
                2:       m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Each token beat is matched against the oldest one owed.
    always @(posedge aclk) begin : token_check
        logic [TOKEN_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_due.size() == 0) begin
                $display("%0t: token beat with none owed: expected none, actual %0d",
                         $time, m_tdata[TOKEN_W-1:0]);
                errors++;
            end else begin
                want = token_due.pop_front();
                if (m_tdata[TOKEN_W-1:0] !== want) begin
                    $display("%0t: token mismatch: expected %0d, actual %0d",
                             $time, want, m_tdata[TOKEN_W-1:0]);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Hand-built trie covering the field extremes and the corner cases noted below.
    task automatic test_directed();
        put_link(0, "a", 1);
        put_link(1, "z", 63);
        put_token(63, 15);
        put_token(1, 7);
        put_char("a", 1'b1);                // single-letter keyword -> 7
        put_char("a", 1'b0);
        put_link(63, "m", 2);               // load beats mid-word leave the walk alone
        put_token(0, 3);
        put_char("z", 1'b1);                // -> 15
        send_beat(KIND_UNUSED, 6'h3f, 8'hff, 6'h3f, 4'hf, 1'b1);  // swallowed
        put_link(0, "a" - 1, 5);            // letters just outside the range: ignored
        put_link(0, "z" + 1, 5);
        put_link(0, 8'hff, 5);
        put_link(0, 8'h00, 5);
        put_char("a" - 1, 1'b1);            // bad character on the final beat -> 0
        put_char(8'hff, 1'b0);              // mismatch is sticky to the word end
        put_char("a", 1'b1);
        put_char("b", 1'b1);                // missing link -> 0
        put_char(8'h00, 1'b1);
        put_link(63, "z", 63);              // self loop
        put_char("a", 1'b0);
        put_char("z", 1'b0);
        put_char("z", 1'b0);
        put_char("z", 1'b1);                // -> 15
        put_link(1, "z", 0);                // clearing a link
        put_token(63, 0);
        put_char("a", 1'b0);
        put_char("z", 1'b1);                // -> 0
    endtask

    // Grow the trie with keywords and walk it, mostly along real paths.
    task automatic test_random_words(input int n_beats);
        logic [SYM_W-1:0] word [$];
        int               opts [$];
        int               stop, r, len, nd, letter, ch, pick;
        stop = beats_sent + n_beats;
        while (beats_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // add a keyword: follow existing links, create missing ones
                nd  = 0;
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++) begin
                    // a few letters most of the time so prefixes get shared
                    letter = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LETTERS - 1)
                                                         : $urandom_range(0, 5);
                    if (link_mem[nd * LETTERS + letter] == '0) begin
                        ch = fresh_node;
                        if (fresh_node < NODES - 1)
                            fresh_node++;
                        else
                            fresh_node = $urandom_range(1, NODES - 1);
                        put_link(nd, FIRST_LETTER + letter, ch);
                    end
                    nd = link_mem[nd * LETTERS + letter];
                end
                put_token(nd, $urandom_range(0, TOKENS - 1));
            end else if (r < 17) begin
                // stray load with fully random fields (clears and odd symbols too)
                send_beat(KIND_W'($urandom_range(0, 1)), NODE_W'($urandom),
                          ($urandom_range(0, 1) != 0) ? SYM_W'($urandom)
                              : SYM_W'(FIRST_LETTER + $urandom_range(0, LETTERS - 1)),
                          NODE_W'($urandom), TOKEN_W'($urandom), 1'($urandom));
            end else if (r < 19) begin
                send_beat(KIND_UNUSED, NODE_W'($urandom), SYM_W'($urandom),
                          NODE_W'($urandom), TOKEN_W'($urandom), 1'($urandom));
            end else if (r < 85) begin
                // well-formed word along existing links, sometimes corrupted
                word.delete();
                nd  = 0;
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    opts.delete();
                    for (int l = 0; l < LETTERS; l++)
                        if (link_mem[nd * LETTERS + l] != '0) opts.push_back(l);
                    if (opts.size() == 0) break;
                    pick = opts[$urandom_range(0, opts.size() - 1)];
                    word.push_back(SYM_W'(FIRST_LETTER + pick));
                    nd = link_mem[nd * LETTERS + pick];
                end
                if (word.size() == 0)
                    word.push_back(SYM_W'(FIRST_LETTER + $urandom_range(0, LETTERS - 1)));
                if ($urandom_range(0, 9) == 0)
                    word[$urandom_range(0, word.size() - 1)] = SYM_W'($urandom);
                for (int i = 0; i < word.size(); i++) begin
                    if ($urandom_range(0, 15) == 0)
                        put_token($urandom_range(0, NODES - 1), $urandom_range(0, TOKENS - 1));
                    put_char(word[i], i == word.size() - 1);
                end
            end else begin
                // junk word: random bytes and letters
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    put_char(($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
                                 : FIRST_LETTER + $urandom_range(0, LETTERS - 1),
                             i == len - 1);
            end
        end
    endtask

    // Receiver holds off for a long stretch while short words keep coming,
    // so the result path fills and the block must stall its input.
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 80; i++)
            put_char(FIRST_LETTER + $urandom_range(0, 5), 1'($urandom_range(0, 1)));
        put_char(FIRST_LETTER + $urandom_range(0, 5), 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Sequencing. The block clears its link memory after reset with
    // s_tready low; the first send simply waits for it.
    // ---------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_words(1220);
        test_backpressure();

        while (token_due.size() != 0) @(posedge aclk);
        // wait on past the last owed token to catch stray beats
        repeat (16) @(posedge aclk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
sv/ktm_pkg.sv
sv/keyword_trie_matcher.sv
sim/keyword_trie_matcher_tb.sv
